FILE: sv/vcsr_pkg.sv
// ----------------------------------------------------------------------------
// vcsr_pkg
// Shared types, register codes and arithmetic helpers of the variable
// coefficient stencil residual unit.
// ----------------------------------------------------------------------------
package vcsr_pkg;

    // grid limits handed to the top level as parameter defaults
    localparam int DEF_MAX_X = 32;
    localparam int DEF_MAX_Y = 32;
    localparam int DEF_MAX_Z = 64;
    localparam int DEF_CELLS = DEF_MAX_X * DEF_MAX_Y * DEF_MAX_Z;

    // one stored cell: concentration in the upper half, field in the lower
    localparam int CELL_W = 64;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DZ   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BND  = 3'd6;

    localparam logic [5:0]  RST_GRID_X  = 6'd32;
    localparam logic [5:0]  RST_GRID_Y  = 6'd32;
    localparam logic [6:0]  RST_GRID_Z  = 7'd64;
    localparam logic [30:0] RST_INV     = 31'd65536;
    localparam logic [31:0] RST_LOW_BND = 32'd65536;

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    // item kinds and result status
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // shared multiply unit: signed 34 x signed 18, accumulated at 68 bits
    localparam int MA_W      = 34;
    localparam int MB_W      = 18;
    localparam int ACC_W     = 68;
    localparam int MAC_SHIFT = 16;

    // width of the residual and diagonal sums
    localparam int SUM_W = 50;

    typedef struct packed {
        logic               kind;
        logic [4:0]         pos_x;
        logic [4:0]         pos_y;
        logic [5:0]         pos_z;
        logic signed [31:0] conc;
        logic signed [31:0] field_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] residual;
        logic signed [31:0] diagonal;
        logic               status;
    } t_out_item;

    typedef struct packed {
        logic first;   // load the product
        logic accum;   // add the product shifted up by MAC_SHIFT
    } t_mac_ctl;

    // saturate a wide signed value to 32 bits signed
    function automatic logic signed [31:0] f_sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-32:0] top;
        top = v[ACC_W-1:31];
        if ((&top) || (~|top)) begin
            return v[31:0];
        end else if (v[ACC_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

FILE: sv/variable_coefficient_stencil_residual_unit.sv
// ----------------------------------------------------------------------------
// variable_coefficient_stencil_residual_unit
// Seven-point variable coefficient stencil residual and diagonal over a
// stored 3D grid, computed by one shared multiply unit under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries load and
//   query beats. A load inside the grid writes one cell of the grid store
//   in the beat's cycle and gives no result; one outside it is dropped. The
//   next beat can follow at once. A query reads the center and its six
//   neighbors from the store through one read port, then runs the three
//   axes in turn through the shared multiplier. The input stalls until a
//   query's result is in the result register. A query with a bad coordinate
//   skips the reads and the axes and returns status 1 from the final step.
//   Output channel (o_out_valid / i_out_stall / o_out_data) is one result
//   register: a finished result waits there while the receiver stalls, and
//   the sequencer holds its last step until the register is free.
//   Config writes (i_cfg_we / i_cfg_idx / i_cfg_data) are registered and
//   must come while no query is in flight.
//   Reset (synchronous, active low) idles the sequencer, empties the result
//   register and restores the register defaults; the store is not cleared,
//   so every cell a query touches must be loaded first.
// ----------------------------------------------------------------------------
module variable_coefficient_stencil_residual_unit #(
    parameter int MAX_X = vcsr_pkg::DEF_MAX_X,
    parameter int MAX_Y = vcsr_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vcsr_pkg::DEF_MAX_Z
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  vcsr_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output vcsr_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [vcsr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vcsr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CELLS    = MAX_X * MAX_Y * MAX_Z;
    localparam int AW       = $clog2(CELLS);
    localparam int X_STRIDE = MAX_Y * MAX_Z;
    localparam int ACC_W    = vcsr_pkg::ACC_W;
    localparam int SUM_W    = vcsr_pkg::SUM_W;

    // read slots, in issue order
    localparam logic [2:0] RD_CTR  = 3'd0;
    localparam logic [2:0] RD_XP   = 3'd1;
    localparam logic [2:0] RD_XM   = 3'd2;
    localparam logic [2:0] RD_YP   = 3'd3;
    localparam logic [2:0] RD_YM   = 3'd4;
    localparam logic [2:0] RD_ZP   = 3'd5;
    localparam logic [2:0] RD_ZM   = 3'd6;
    localparam logic [2:0] RD_LAST = 3'd7;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_READ  = 10'b00_0000_0010,
        S_DQ    = 10'b00_0000_0100,
        S_TM_LO = 10'b00_0000_1000,
        S_TM_HI = 10'b00_0001_0000,
        S_ADD   = 10'b00_0010_0000,
        S_FD_LO = 10'b00_0100_0000,
        S_FD_HI = 10'b00_1000_0000,
        S_SAT   = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } t_state;

    function automatic logic [AW-1:0] f_addr(input logic [5:0] x, input logic [5:0] y,
                                             input logic [5:0] z);
        int a;
        a = int'(x) * X_STRIDE + int'(y) * MAX_Z + int'(z);
        return a[AW-1:0];
    endfunction

    // configuration
    logic [5:0]         r_grid_x;
    logic [5:0]         r_grid_y;
    logic [6:0]         r_grid_z;
    logic [30:0]        r_inv_dx;
    logic [30:0]        r_inv_dy;
    logic [30:0]        r_inv_dz;
    logic signed [31:0] r_low_bnd;

    // sequencer
    t_state      r_state;
    t_state      n_state;
    logic [2:0]  r_rd;
    logic [1:0]  r_axis;
    logic        r_side;
    logic        r_diag;
    logic        r_err;

    // query operands
    logic [5:0]         r_x, r_y, r_z;
    logic [5:0]         r_xp, r_xm, r_yp, r_ym;
    logic signed [31:0] r_c, r_e;
    logic signed [31:0] r_nc [6];
    logic signed [31:0] r_ne [6];
    logic signed [31:0] r_t;
    logic signed [SUM_W-1:0] r_res, r_dia;

    logic                r_out_valid;
    vcsr_pkg::t_out_item r_out_data;

    // combinational
    logic [5:0]  w_gx, w_gy;
    logic [6:0]  w_gz;
    logic        w_accept, w_out_free;
    logic [5:0]  w_x, w_y, w_z, w_xp, w_xm, w_yp, w_ym;
    logic        w_ld_ok, w_q_bad, w_we, w_zp_top, w_shift;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [vcsr_pkg::CELL_W-1:0] w_rdata;
    logic signed [31:0] w_rd_c, w_rd_e, w_ne_in;
    logic [32:0] w_s, w_d;
    logic [34:0] w_q;
    logic signed [34:0] w_nq, w_half;
    logic signed [31:0] w_dq_sat, w_fsat;
    logic signed [ACC_W-1:0] w_acc, w_sh16;
    logic signed [SUM_W-1:0] w_term;
    logic [30:0] w_inv;
    logic signed [vcsr_pkg::MA_W-1:0] w_mac_a;
    logic signed [vcsr_pkg::MB_W-1:0] w_mac_b;
    vcsr_pkg::t_mac_ctl w_mac_ctl;

    // grid sizes clamped to the store
    assign w_gx = (int'(r_grid_x) > MAX_X) ? 6'(MAX_X) : r_grid_x;
    assign w_gy = (int'(r_grid_y) > MAX_Y) ? 6'(MAX_Y) : r_grid_y;
    assign w_gz = (int'(r_grid_z) > MAX_Z) ? 7'(MAX_Z) : r_grid_z;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_x = {1'b0, i_in_data.pos_x};
    assign w_y = {1'b0, i_in_data.pos_y};
    assign w_z = i_in_data.pos_z;

    assign w_ld_ok = (w_x < w_gx) && (w_y < w_gy) && ({1'b0, w_z} < w_gz);
    assign w_q_bad = !(w_x < w_gx) || !(w_y < w_gy) || (w_gz < 7'd3) || (w_z == 6'd0)
                   || (({1'b0, w_z} + 7'd2) > w_gz);
    assign w_we    = w_accept && (i_in_data.kind == vcsr_pkg::KIND_LOAD) && w_ld_ok;

    // periodic neighbors along x and y
    assign w_xp = ((w_x + 6'd1) == w_gx) ? 6'd0 : w_x + 6'd1;
    assign w_xm = (w_x == 6'd0) ? w_gx - 6'd1 : w_x - 6'd1;
    assign w_yp = ((w_y + 6'd1) == w_gy) ? 6'd0 : w_y + 6'd1;
    assign w_ym = (w_y == 6'd0) ? w_gy - 6'd1 : w_y - 6'd1;

    assign w_waddr = f_addr(w_x, w_y, w_z);

    always_comb begin
        unique case (r_rd)
            RD_XP:   w_raddr = f_addr(r_xp, r_y, r_z);
            RD_XM:   w_raddr = f_addr(r_xm, r_y, r_z);
            RD_YP:   w_raddr = f_addr(r_x, r_yp, r_z);
            RD_YM:   w_raddr = f_addr(r_x, r_ym, r_z);
            RD_ZP:   w_raddr = f_addr(r_x, r_y, r_z + 6'd1);
            RD_ZM:   w_raddr = f_addr(r_x, r_y, r_z - 6'd1);
            default: w_raddr = f_addr(r_x, r_y, r_z);
        endcase
    end

    vcsr_ram #(
        .WIDTH(vcsr_pkg::CELL_W),
        .DEPTH(CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_in_data.conc, i_in_data.field_value}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_c = w_rdata[63:32];
    assign w_rd_e = w_rdata[31:0];

    // boundary planes replace the stored field value
    assign w_zp_top = (({1'b0, r_z} + 7'd2) == w_gz);
    always_comb begin
        priority if ((r_rd == RD_ZP + 3'd1) && w_zp_top) begin
            w_ne_in = vcsr_pkg::ONE_Q16;
        end else if ((r_rd == RD_ZM + 3'd1) && (r_z == 6'd1)) begin
            w_ne_in = r_low_bnd;
        end else begin
            w_ne_in = w_rd_e;
        end
    end

    assign w_shift = ((r_state == S_READ) && (r_rd >= RD_XM))
                   || ((r_state == S_ADD) && !r_diag);

    // term operands, from the head of the neighbor line; the diagonal term also uses the entry behind it
    assign w_s = {r_nc[0][31], r_nc[0]} + {r_c[31], r_c};
    assign w_d = {r_ne[0][31], r_ne[0]} - {r_e[31], r_e};
    assign w_q = {{3{r_nc[0][31]}}, r_nc[0]} + {{2{r_c[31]}}, r_c, 1'b0}
               + {{3{r_nc[1][31]}}, r_nc[1]};
    assign w_nq     = 35'd0 - w_q;
    assign w_half   = w_nq >>> 1;
    assign w_dq_sat = vcsr_pkg::f_sat32({{(ACC_W-35){w_half[34]}}, w_half});
    assign w_fsat   = vcsr_pkg::f_sat32(w_acc >>> 17);
    assign w_sh16   = w_acc >>> 16;
    assign w_term   = w_sh16[SUM_W-1:0];

    always_comb begin
        unique case (r_axis)
            AX_X:    w_inv = r_inv_dx;
            AX_Y:    w_inv = r_inv_dy;
            default: w_inv = r_inv_dz;
        endcase
    end

    always_comb begin
        w_mac_ctl.first = (r_state == S_FD_LO) || (r_state == S_TM_LO);
        w_mac_ctl.accum = (r_state == S_FD_HI) || (r_state == S_TM_HI);
        unique case (r_state)
            S_FD_LO: begin
                w_mac_a = {w_s[32], w_s};
                w_mac_b = {2'b00, w_d[15:0]};
            end
            S_FD_HI: begin
                w_mac_a = {w_s[32], w_s};
                w_mac_b = {w_d[32], w_d[32:16]};
            end
            S_TM_LO: begin
                w_mac_a = {{2{r_t[31]}}, r_t};
                w_mac_b = {2'b00, w_inv[15:0]};
            end
            default: begin
                w_mac_a = {{2{r_t[31]}}, r_t};
                w_mac_b = {3'b000, w_inv[30:16]};
            end
        endcase
    end

    vcsr_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_a   (w_mac_a),
        .i_b   (w_mac_b),
        .o_acc (w_acc)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_data.kind == vcsr_pkg::KIND_QUERY)) begin
                    n_state = w_q_bad ? S_FIN : S_READ;
                end
            end
            S_READ: begin
                if (r_rd == RD_LAST) begin
                    n_state = S_DQ;
                end
            end
            S_DQ:    n_state = S_TM_LO;
            S_TM_LO: n_state = S_TM_HI;
            S_TM_HI: n_state = S_ADD;
            S_ADD: begin
                if (r_diag || !r_side) begin
                    n_state = S_FD_LO;
                end else if (r_axis == AX_Z) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_DQ;
                end
            end
            S_FD_LO: n_state = S_FD_HI;
            S_FD_HI: n_state = S_SAT;
            S_SAT:   n_state = S_TM_LO;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd        <= RD_CTR;
            r_axis      <= AX_X;
            r_side      <= 1'b0;
            r_diag      <= 1'b0;
            r_out_valid <= 1'b0;
            r_grid_x    <= vcsr_pkg::RST_GRID_X;
            r_grid_y    <= vcsr_pkg::RST_GRID_Y;
            r_grid_z    <= vcsr_pkg::RST_GRID_Z;
            r_inv_dx    <= vcsr_pkg::RST_INV;
            r_inv_dy    <= vcsr_pkg::RST_INV;
            r_inv_dz    <= vcsr_pkg::RST_INV;
            r_low_bnd   <= vcsr_pkg::RST_LOW_BND;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vcsr_pkg::CFG_GRID_X:  r_grid_x  <= i_cfg_data[5:0];
                    vcsr_pkg::CFG_GRID_Y:  r_grid_y  <= i_cfg_data[5:0];
                    vcsr_pkg::CFG_GRID_Z:  r_grid_z  <= i_cfg_data[6:0];
                    vcsr_pkg::CFG_INV_DX:  r_inv_dx  <= i_cfg_data[30:0];
                    vcsr_pkg::CFG_INV_DY:  r_inv_dy  <= i_cfg_data[30:0];
                    vcsr_pkg::CFG_INV_DZ:  r_inv_dz  <= i_cfg_data[30:0];
                    vcsr_pkg::CFG_LOW_BND: r_low_bnd <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_state == S_IDLE) begin
                r_rd   <= RD_CTR;
                r_axis <= AX_X;
                r_side <= 1'b0;
                r_diag <= 1'b0;
            end
            if (r_state == S_READ) begin
                r_rd <= r_rd + 3'd1;
            end
            if (r_state == S_DQ) begin
                r_diag <= 1'b1;
            end
            if (r_state == S_ADD) begin
                r_diag <= 1'b0;
                if (!r_diag) begin
                    r_side <= !r_side;
                    if (r_side && (r_axis != AX_Z)) begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
            end

            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x   <= w_x;
            r_y   <= w_y;
            r_z   <= w_z;
            r_xp  <= w_xp;
            r_xm  <= w_xm;
            r_yp  <= w_yp;
            r_ym  <= w_ym;
            r_err <= w_q_bad;
            r_res <= '0;
            r_dia <= '0;
        end
        if ((r_state == S_READ) && (r_rd == RD_CTR + 3'd1)) begin
            r_c <= w_rd_c;
            r_e <= w_rd_e;
        end
        if (w_shift) begin
            for (int i = 0; i < 5; i++) begin
                r_nc[i] <= r_nc[i+1];
                r_ne[i] <= r_ne[i+1];
            end
            r_nc[5] <= w_rd_c;
            r_ne[5] <= w_ne_in;
        end
        if (r_state == S_DQ) begin
            r_t <= w_dq_sat;
        end
        if (r_state == S_SAT) begin
            r_t <= w_fsat;
        end
        if (r_state == S_ADD) begin
            if (r_diag) begin
                r_dia <= r_dia + w_term;
            end else begin
                r_res <= r_res + w_term;
            end
        end
        if ((r_state == S_FIN) && w_out_free) begin
            if (r_err) begin
                r_out_data.residual <= '0;
                r_out_data.diagonal <= '0;
                r_out_data.status   <= vcsr_pkg::STATUS_BAD;
            end else begin
                r_out_data.residual <= vcsr_pkg::f_sat32({{(ACC_W-SUM_W){r_res[SUM_W-1]}}, r_res});
                r_out_data.diagonal <= vcsr_pkg::f_sat32({{(ACC_W-SUM_W){r_dia[SUM_W-1]}}, r_dia});
                r_out_data.status   <= vcsr_pkg::STATUS_OK;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a result beat only appears after the final sequencer step
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result valid rose outside the final step");

    // an error result carries zero values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.status == vcsr_pkg::STATUS_BAD))
        |-> (r_out_data.residual == '0) && (r_out_data.diagonal == '0))
        else $error("error result with nonzero values");

    // reads always start a query on the first axis and first side
    a_read_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_axis == AX_X) && !r_side && !r_diag)
        else $error("axis sequencer not reset at read phase");

    // the sequencer finishes after the last z term, keeping the axis counter within the three axes
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) && r_side && !r_diag && (r_axis == AX_Z) |=> (r_state == S_FIN))
        else $error("sequencer did not finish after the last z term");

endmodule

FILE: sv/vcsr_ram.sv
// ----------------------------------------------------------------------------
// vcsr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vcsr_ram #(
    parameter int WIDTH = vcsr_pkg::CELL_W,
    parameter int DEPTH = vcsr_pkg::DEF_CELLS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/vcsr_mac.sv
// ----------------------------------------------------------------------------
// vcsr_mac
// Shared multiply unit: one signed 34 x 18 product per cycle, either loaded
// or added at a 16 bit offset, so a wide product is built in two passes.
// ----------------------------------------------------------------------------
module vcsr_mac (
    input  logic                                  i_clk,
    input  vcsr_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [vcsr_pkg::MA_W-1:0]      i_a,
    input  logic signed [vcsr_pkg::MB_W-1:0]      i_b,
    output logic signed [vcsr_pkg::ACC_W-1:0]     o_acc
);

    localparam int PW = vcsr_pkg::MA_W + vcsr_pkg::MB_W;

    logic signed [PW-1:0]              w_p;
    logic signed [vcsr_pkg::ACC_W-1:0] w_pe;
    logic signed [vcsr_pkg::ACC_W-1:0] r_acc;

    assign w_p  = i_a * i_b;
    assign w_pe = {{(vcsr_pkg::ACC_W - PW){w_p[PW-1]}}, w_p};

    // both controls low holds the accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.first) begin
            r_acc <= w_pe;
        end else if (i_ctl.accum) begin
            r_acc <= r_acc + (w_pe <<< vcsr_pkg::MAC_SHIFT);
        end
    end

    assign o_acc = r_acc;

endmodule
